// File: design/period_to_speed_meter_macros.svh
// ----------------------------------------------------------------------------
// period_to_speed_meter_macros.svh
// Assertion shorthands for the speed meter checker.
// ----------------------------------------------------------------------------
`ifndef PERIOD_TO_SPEED_METER_MACROS_SVH
`define PERIOD_TO_SPEED_METER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTSM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/ptsm_pkg.sv
// ----------------------------------------------------------------------------
// ptsm_pkg
// Shared widths, register codes, reset values and types of the speed meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptsm_pkg;

    localparam int DIVIDEND_W   = 24;
    localparam int PRESCALE_W   = 16;
    localparam int SPEED_W      = 8;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_INDEX_W  = 2;
    localparam int TDATA_W      = 8;
    localparam int PERIOD_W_DEF = 16;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_DIVIDEND        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TICK_PRESCALE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPORT_PRESCALE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPORT_RELOAD   = 2'd3;

    localparam logic [DIVIDEND_W-1:0] DIVIDEND_RST        = 24'd762500;
    localparam logic [PRESCALE_W-1:0] TICK_PRESCALE_RST   = 16'd63;
    localparam logic [PRESCALE_W-1:0] REPORT_PRESCALE_RST = 16'd999;
    localparam logic [PRESCALE_W-1:0] REPORT_RELOAD_RST   = 16'd15999;

    localparam logic [SPEED_W-1:0] SPEED_SAT  = 8'd255;
    localparam logic [SPEED_W-1:0] SPEED_ZERO = 8'd0;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [SPEED_W-1:0] speed;
    } div_stat_t;

endpackage

`default_nettype wire

// File: design/ptsm_timer.sv
// ----------------------------------------------------------------------------
// ptsm_timer
// Step-enabled counter that returns to zero once it has reached its limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptsm_timer #(
    parameter int WIDTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic             clear,
    input  logic [WIDTH-1:0] limit,
    output logic [WIDTH-1:0] count,
    output logic             wrap
);

    logic [WIDTH-1:0] count_reg;
    logic [WIDTH-1:0] count_next;

    // count beyond limit (after a register write) wraps like equality
    assign wrap  = step && (count_reg >= limit);
    assign count = count_reg;

    always_comb begin
        count_next = count_reg;
        if (clear) begin
            count_next = '0;
        end else if (step) begin
            count_next = wrap ? '0 : count_reg + {{(WIDTH-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: design/ptsm_div.sv
// ----------------------------------------------------------------------------
// ptsm_div
// Bit-serial restoring divider: dividend over period, saturated to a byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptsm_div #(
    parameter int PERIOD_WIDTH = ptsm_pkg::PERIOD_W_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [ptsm_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [PERIOD_WIDTH-1:0]         divisor,
    output ptsm_pkg::div_stat_t             stat
);

    import ptsm_pkg::*;

    localparam int STEP_W = $clog2(DIVIDEND_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

    logic                    running_reg, running_next;
    logic                    done_reg, done_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [DIVIDEND_W-1:0]   dvd_reg, dvd_next;
    logic [PERIOD_WIDTH-1:0] dvs_reg, dvs_next;
    logic [PERIOD_WIDTH:0]   rem_reg, rem_next;
    logic [SPEED_W-1:0]      quot_reg, quot_next;
    logic                    ovf_reg, ovf_next;

    logic [PERIOD_WIDTH:0]   rem_shift;
    logic                    fits;

    // one quotient bit per cycle, dividend shifted in MSB first
    assign rem_shift = {rem_reg[PERIOD_WIDTH-1:0], dvd_reg[DIVIDEND_W-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_comb begin
        running_next = running_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        dvd_next     = dvd_reg;
        dvs_next     = dvs_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        ovf_next     = ovf_reg;
        if (start) begin
            running_next = 1'b1;
            step_next    = '0;
            dvd_next     = dividend;
            dvs_next     = divisor;
            rem_next     = '0;
            quot_next    = '0;
            ovf_next     = 1'b0;
        end else if (running_reg) begin
            dvd_next  = {dvd_reg[DIVIDEND_W-2:0], 1'b0};
            rem_next  = fits ? rem_shift - {1'b0, dvs_reg} : rem_shift;
            quot_next = {quot_reg[SPEED_W-2:0], fits};
            // any quotient bit above the byte means saturation
            ovf_next  = ovf_reg | quot_reg[SPEED_W-1];
            step_next = step_reg + {{(STEP_W-1){1'b0}}, 1'b1};
            if (step_reg == LAST_STEP) begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            step_reg    <= '0;
        end else begin
            running_reg <= running_next;
            done_reg    <= done_next;
            step_reg    <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    // zero period divides to all ones, so it saturates here as well
    assign stat.busy  = running_reg || done_reg;
    assign stat.done  = done_reg;
    assign stat.speed = (ovf_reg || quot_reg == SPEED_ZERO) ? SPEED_SAT : quot_reg;

endmodule

`default_nettype wire

// File: design/ptsm_ofifo.sv
// ----------------------------------------------------------------------------
// ptsm_ofifo
// Two-entry result queue between the meter core and the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptsm_ofifo (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  logic [ptsm_pkg::SPEED_W-1:0] push_data,
    input  logic                         pop,
    output logic                         valid,
    output logic [ptsm_pkg::SPEED_W-1:0] data,
    output logic                         has_room
);

    import ptsm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

    logic [SPEED_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign valid    = count_reg != '0;
    assign data     = mem_reg[rd_ptr_reg];
    assign has_room = count_reg != FULL;
    assign do_pop   = pop && valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + {{(PTR_W-1){1'b0}}, 1'b1} : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + {{(PTR_W-1){1'b0}}, 1'b1} : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + {{(CNT_W-1){1'b0}}, 1'b1};
        end else if (do_pop && !push) begin
            count_next = count_reg - {{(CNT_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: design/period_to_speed_meter.sv
// ----------------------------------------------------------------------------
// period_to_speed_meter
// Wheel tachometer: period measurement, serial division, periodic report.
// ----------------------------------------------------------------------------
// Each input beat is one sample of the wheel sensor. Samples are taken one per
// clock while the sensor holds no rising edge; a rising edge starts the
// bit-serial divider (one quotient bit per cycle over the 24-bit dividend),
// and input stalls while it runs and while its done flag is up. Input also
// stalls while the two-entry result queue is full. Timers and counters advance
// per accepted sample, not per clock. Configuration writes take effect at once
// and are meant for idle periods only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module period_to_speed_meter #(
    parameter int PERIOD_WIDTH = ptsm_pkg::PERIOD_W_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ptsm_pkg::TDATA_W-1:0]     s_tdata,   // [0] sensor_level
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ptsm_pkg::TDATA_W-1:0]     m_tdata,   // [7:0] speed_byte
    input  logic                             cfg_wr_en,
    input  logic [ptsm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ptsm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import ptsm_pkg::*;

    localparam logic [PERIOD_WIDTH-1:0] PERIOD_MAX = {PERIOD_WIDTH{1'b1}};

    logic [DIVIDEND_W-1:0] dividend_reg;
    logic [PRESCALE_W-1:0] tick_prescale_reg;
    logic [PRESCALE_W-1:0] report_prescale_reg;
    logic [PRESCALE_W-1:0] report_reload_reg;

    logic                  prev_level_reg, prev_level_next;
    logic [SPEED_W-1:0]    speed_reg, speed_next;
    logic                  pend_reg, pend_next;

    logic                    accept;
    logic                    level;
    logic                    rising;
    logic                    tick;
    logic                    period_wrap;
    logic [PERIOD_WIDTH-1:0] period_count;
    logic                    report_tick;
    logic                    report_fire;
    div_stat_t               div_stat;
    logic                    push;
    logic [SPEED_W-1:0]      push_data;
    logic                    room;
    logic [SPEED_W-1:0]      out_speed;

    assign s_tready = !div_stat.busy && room;
    assign accept   = s_tvalid && s_tready;
    assign level    = s_tdata[0];
    assign rising   = level && !prev_level_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dividend_reg        <= DIVIDEND_RST;
            tick_prescale_reg   <= TICK_PRESCALE_RST;
            report_prescale_reg <= REPORT_PRESCALE_RST;
            report_reload_reg   <= REPORT_RELOAD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DIVIDEND:        dividend_reg        <= cfg_wdata;
                REG_TICK_PRESCALE:   tick_prescale_reg   <= cfg_wdata[PRESCALE_W-1:0];
                REG_REPORT_PRESCALE: report_prescale_reg <= cfg_wdata[PRESCALE_W-1:0];
                REG_REPORT_RELOAD:   report_reload_reg   <= cfg_wdata[PRESCALE_W-1:0];
                default: ;
            endcase
        end
    end

    ptsm_timer #(.WIDTH(PRESCALE_W)) u_tick_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .clear   (1'b0),
        .limit   (tick_prescale_reg),
        .count   (),
        .wrap    (tick)
    );

    // edge wins over a wrap in the same beat; that beat's tick is lost
    ptsm_timer #(.WIDTH(PERIOD_WIDTH)) u_period (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (tick),
        .clear   (accept && rising),
        .limit   (PERIOD_MAX),
        .count   (period_count),
        .wrap    (period_wrap)
    );

    ptsm_timer #(.WIDTH(PRESCALE_W)) u_report_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .clear   (1'b0),
        .limit   (report_prescale_reg),
        .count   (),
        .wrap    (report_tick)
    );

    ptsm_timer #(.WIDTH(PRESCALE_W)) u_report_cnt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (report_tick),
        .clear   (1'b0),
        .limit   (report_reload_reg),
        .count   (),
        .wrap    (report_fire)
    );

    ptsm_div #(.PERIOD_WIDTH(PERIOD_WIDTH)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && rising),
        .dividend (dividend_reg),
        .divisor  (period_count),
        .stat     (div_stat)
    );

    // a report on an edge beat waits for the quotient
    always_comb begin
        prev_level_next = prev_level_reg;
        speed_next      = speed_reg;
        pend_next       = pend_reg;
        push            = 1'b0;
        push_data       = speed_reg;
        if (div_stat.done) begin
            speed_next = div_stat.speed;
            pend_next  = 1'b0;
            push       = pend_reg;
            push_data  = div_stat.speed;
        end else if (accept) begin
            prev_level_next = level;
            if (rising) begin
                pend_next = report_fire;
            end else begin
                if (period_wrap) begin
                    speed_next = SPEED_ZERO;
                end
                push      = report_fire;
                push_data = period_wrap ? SPEED_ZERO : speed_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= 1'b1;
            speed_reg      <= SPEED_ZERO;
            pend_reg       <= 1'b0;
        end else begin
            prev_level_reg <= prev_level_next;
            speed_reg      <= speed_next;
            pend_reg       <= pend_next;
        end
    end

    ptsm_ofifo u_ofifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (m_tready),
        .valid     (m_tvalid),
        .data      (out_speed),
        .has_room  (room)
    );

    assign m_tdata = TDATA_W'(out_speed);

endmodule

`default_nettype wire

// File: design/ptsm_checker.sv
// ----------------------------------------------------------------------------
// ptsm_checker
// Port-level checks of the speed meter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "period_to_speed_meter_macros.svh"

module ptsm_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_tvalid,
    input wire                             s_tready,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [ptsm_pkg::TDATA_W-1:0]     m_tdata
);

    `PTSM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped")

    `PTSM_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")

    // input only stalls after taking a beat (divider start or queue filled)
    `PTSM_ASSERT_SAME(a_stall_cause, $fell(s_tready), $past(s_tvalid && s_tready), "stall without beat")

    // when input has just stalled on the divider with an empty queue, no result follows yet
    `PTSM_ASSERT_NEXT(a_no_spurious, !s_tready && !m_tvalid && $past(s_tready), !m_tvalid, "unexpected result")

endmodule

bind period_to_speed_meter ptsm_checker u_ptsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
